// File: sv/psa_pkg.sv
// Shared types and codes of the paged stack allocator.
package psa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_TOO_SMALL  = 3'd1,
        STATUS_TABLE_FULL = 3'd2,
        STATUS_NO_MARK    = 3'd3,
        STATUS_MARKS_FULL = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] size;
        logic [4:0]  align_log2;
    } psa_req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  page_index;
        logic [31:0] offset;
        logic        new_page;
        logic [31:0] page_capacity;
    } psa_rsp_t;

endpackage

// File: sv/psa_page_mem.sv
// Page table memory: capacity and fill per page, two read ports, one write port.
module psa_page_mem #(
    parameter int DEPTH   = 16,
    parameter int ADDR_W  = 4,
    parameter int DATA_W  = 32
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_cap_a,
    output logic [DATA_W-1:0] rd_fill_a,
    output logic [DATA_W-1:0] rd_cap_b,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_cap_en,
    input  logic              wr_fill_en,
    input  logic [DATA_W-1:0] wr_cap,
    input  logic [DATA_W-1:0] wr_fill
);

    logic [DATA_W-1:0] cap_mem  [DEPTH];
    logic [DATA_W-1:0] fill_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_cap_en)
        begin
            cap_mem[wr_addr] <= wr_cap;
        end
        if (wr_fill_en)
        begin
            fill_mem[wr_addr] <= wr_fill;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cap_a  <= cap_mem[rd_addr_a];
        rd_fill_a <= fill_mem[rd_addr_a];
        rd_cap_b  <= cap_mem[rd_addr_b];
    end

endmodule

// File: sv/psa_mark_mem.sv
// Mark stack memory: saved page, fill and capacity per mark.
module psa_mark_mem #(
    parameter int DEPTH   = 16,
    parameter int ADDR_W  = 4,
    parameter int PAGE_W  = 4,
    parameter int DATA_W  = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PAGE_W-1:0] wr_page,
    input  logic [DATA_W-1:0] wr_fill,
    input  logic [DATA_W-1:0] wr_cap,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PAGE_W-1:0] rd_page,
    output logic [DATA_W-1:0] rd_fill,
    output logic [DATA_W-1:0] rd_cap
);

    logic [PAGE_W+2*DATA_W-1:0] mark_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[wr_addr] <= {wr_page, wr_fill, wr_cap};
        end
        {rd_page, rd_fill, rd_cap} <= mark_mem[rd_addr];
    end

endmodule

// File: sv/paged_stack_allocator.sv
// Paged bump allocator with a mark stack: control, state registers and memories.
//
// Usage:
//   req carries one command (allocate, push mark, pop mark, reset) as a beat on
//   req_valid/req_ready; rsp returns exactly one result beat per command on
//   rsp_valid/rsp_ready. cfg_data written on cfg_valid/cfg_ready sets the
//   default page size, which is also the capacity of page 0; write it only
//   while no command is in flight.
//   An accepted command enters ST_EXEC, where its result is computed and
//   registered; req_ready is low in ST_EXEC, so no new command is taken until
//   the last one leaves it. Each command reads the page table and mark stack
//   (synchronous memories), then computes and writes back in ST_EXEC.
//   When the receiver stalls, the result register holds its beat; one more
//   command is accepted and waits in the execute cycle until the result
//   register drains, then req_ready stays low.
//   Reset: page 0 current with zero fill, one page in the table, empty mark
//   stack, default page size 65536. No clearing pass; req_ready is high as
//   soon as reset is released.
module paged_stack_allocator #(
    parameter int MAX_PAGES = 16,
    parameter int MAX_MARKS = 16,
    parameter int SIZE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  psa_pkg::psa_req_t req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output psa_pkg::psa_rsp_t rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    import psa_pkg::*;

    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);
    localparam int MARK_W  = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int DEPTH_W = $clog2(MAX_MARKS + 1);
    localparam int SUM_W   = ((SIZE_BITS > 31) ? SIZE_BITS : 31) + 2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                 state_reg, state_next;
    psa_req_t               req_reg, req_next;
    psa_rsp_t               rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [PAGE_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [SIZE_BITS-1:0]   default_reg, default_next;
    logic [MAX_PAGES-1:0]   fill_valid_reg, fill_valid_next;

    logic [SIZE_BITS-1:0]   pg_rd_cap_a, pg_rd_fill_a, pg_rd_cap_b;
    logic [PAGE_W-1:0]      pg_wr_addr;
    logic                   pg_wr_cap_en, pg_wr_fill_en;
    logic [SIZE_BITS-1:0]   pg_wr_cap, pg_wr_fill;
    logic                   mk_wr_en;
    logic [PAGE_W-1:0]      mk_rd_page;
    logic [SIZE_BITS-1:0]   mk_rd_fill, mk_rd_cap;

    logic [SIZE_BITS-1:0]   size_v, cur_fill, cur_cap, next_cap, new_cap;
    logic [SUM_W-1:0]       amask, aligned, end_sum;
    logic [CNT_W-1:0]       cur_plus;
    logic [PAGE_W-1:0]      nxt_page, new_page_idx;
    logic                   fits, has_next, commit;

    // Datapath of allocate: align the fill up, then check the end against capacity.
    assign size_v   = SIZE_BITS'(req_reg.size);
    assign cur_fill = fill_valid_reg[cur_reg] ? pg_rd_fill_a : '0;
    assign cur_cap  = (cur_reg == '0) ? default_reg : pg_rd_cap_a;
    assign next_cap = pg_rd_cap_b;
    assign new_cap  = (size_v > default_reg) ? size_v : default_reg;
    assign amask    = (SUM_W'(1) << req_reg.align_log2) - SUM_W'(1);
    assign aligned  = (SUM_W'(cur_fill) + amask) & ~amask;
    assign end_sum  = aligned + SUM_W'(size_v);
    assign fits     = (end_sum <= SUM_W'(cur_cap));
    assign cur_plus = CNT_W'(cur_reg) + CNT_W'(1);
    assign has_next = (cur_plus < count_reg);
    assign nxt_page = PAGE_W'(cur_plus);
    assign new_page_idx = PAGE_W'(count_reg);
    assign commit   = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        cur_next        = cur_reg;
        count_next      = count_reg;
        depth_next      = depth_reg;
        default_next    = default_reg;
        fill_valid_next = fill_valid_reg;
        pg_wr_addr      = cur_reg;
        pg_wr_cap_en    = 1'b0;
        pg_wr_fill_en   = 1'b0;
        pg_wr_cap       = new_cap;
        pg_wr_fill      = '0;
        mk_wr_en        = 1'b0;

        if (cfg_valid)
        begin
            default_next = SIZE_BITS'(cfg_data);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next              = ST_IDLE;
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = STATUS_OK;
                    rsp_next.page_index     = 4'(cur_reg);
                    rsp_next.offset         = 32'(cur_fill);
                    rsp_next.new_page       = 1'b0;
                    rsp_next.page_capacity  = 32'(cur_cap);
                    case (req_reg.cmd)
                        CMD_ALLOC:
                        begin
                            if (fits)
                            begin
                                pg_wr_fill_en   = 1'b1;
                                pg_wr_fill      = SIZE_BITS'(end_sum);
                                rsp_next.offset = 32'(aligned);
                            end
                            else if (has_next)
                            begin
                                if (size_v > next_cap)
                                begin
                                    rsp_next.status = STATUS_TOO_SMALL;
                                end
                                else
                                begin
                                    // Move on to the next pooled page.
                                    cur_next               = nxt_page;
                                    pg_wr_addr             = nxt_page;
                                    pg_wr_fill_en          = 1'b1;
                                    pg_wr_fill             = size_v;
                                    rsp_next.page_index    = 4'(nxt_page);
                                    rsp_next.offset        = '0;
                                    rsp_next.page_capacity = 32'(next_cap);
                                end
                            end
                            else if (count_reg >= CNT_W'(MAX_PAGES))
                            begin
                                rsp_next.status = STATUS_TABLE_FULL;
                            end
                            else
                            begin
                                // Append a fresh page.
                                cur_next               = new_page_idx;
                                count_next             = count_reg + CNT_W'(1);
                                pg_wr_addr             = new_page_idx;
                                pg_wr_cap_en           = 1'b1;
                                pg_wr_fill_en          = 1'b1;
                                pg_wr_fill             = size_v;
                                rsp_next.page_index    = 4'(new_page_idx);
                                rsp_next.offset        = '0;
                                rsp_next.new_page      = 1'b1;
                                rsp_next.page_capacity = 32'(new_cap);
                            end
                        end
                        CMD_PUSH:
                        begin
                            if (depth_reg >= DEPTH_W'(MAX_MARKS))
                            begin
                                rsp_next.status = STATUS_MARKS_FULL;
                            end
                            else
                            begin
                                mk_wr_en   = 1'b1;
                                depth_next = depth_reg + DEPTH_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (depth_reg == '0)
                            begin
                                rsp_next.status = STATUS_NO_MARK;
                            end
                            else
                            begin
                                depth_next             = depth_reg - DEPTH_W'(1);
                                cur_next               = mk_rd_page;
                                pg_wr_addr             = mk_rd_page;
                                pg_wr_fill_en          = 1'b1;
                                pg_wr_fill             = mk_rd_fill;
                                rsp_next.page_index    = 4'(mk_rd_page);
                                rsp_next.offset        = 32'(mk_rd_fill);
                                // Page 0 capacity follows the live default.
                                rsp_next.page_capacity = (mk_rd_page == '0) ?
                                                         32'(default_reg) : 32'(mk_rd_cap);
                            end
                        end
                        CMD_RESET:
                        begin
                            depth_next             = '0;
                            cur_next               = '0;
                            pg_wr_addr             = '0;
                            pg_wr_fill_en          = 1'b1;
                            pg_wr_fill             = '0;
                            rsp_next.page_index    = '0;
                            rsp_next.offset        = '0;
                            rsp_next.page_capacity = 32'(default_reg);
                        end
                        default:
                        begin
                            rsp_next.status = STATUS_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pg_wr_fill_en)
        begin
            fill_valid_next[pg_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            count_reg      <= CNT_W'(1);
            depth_reg      <= '0;
            default_reg    <= SIZE_BITS'(65536);
            fill_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            rsp_reg        <= rsp_next;
            rsp_valid_reg  <= rsp_valid_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            depth_reg      <= depth_next;
            default_reg    <= default_next;
            fill_valid_reg <= fill_valid_next;
        end
    end

    psa_page_mem #(
        .DEPTH  (MAX_PAGES),
        .ADDR_W (PAGE_W),
        .DATA_W (SIZE_BITS)
    ) u_page_mem (
        .clk        (clk),
        .rd_addr_a  (cur_reg),
        .rd_addr_b  (nxt_page),
        .rd_cap_a   (pg_rd_cap_a),
        .rd_fill_a  (pg_rd_fill_a),
        .rd_cap_b   (pg_rd_cap_b),
        .wr_addr    (pg_wr_addr),
        .wr_cap_en  (pg_wr_cap_en),
        .wr_fill_en (pg_wr_fill_en),
        .wr_cap     (pg_wr_cap),
        .wr_fill    (pg_wr_fill)
    );

    psa_mark_mem #(
        .DEPTH  (MAX_MARKS),
        .ADDR_W (MARK_W),
        .PAGE_W (PAGE_W),
        .DATA_W (SIZE_BITS)
    ) u_mark_mem (
        .clk     (clk),
        .wr_en   (mk_wr_en),
        .wr_addr (MARK_W'(depth_reg)),
        .wr_page (cur_reg),
        .wr_fill (cur_fill),
        .wr_cap  (cur_cap),
        .rd_addr (MARK_W'(depth_reg - DEPTH_W'(1))),
        .rd_page (mk_rd_page),
        .rd_fill (mk_rd_fill),
        .rd_cap  (mk_rd_cap)
    );

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_MARKS))
        else $error("mark depth beyond stack size");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_PAGES))
        else $error("page count out of range");

    a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(cur_reg) < count_reg)
        else $error("current page beyond page count");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == ST_EXEC)
        else $error("accepted command did not enter execute");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && rsp_valid_reg && !rsp_ready |=>
        state_reg == ST_EXEC && $stable(cur_reg) && $stable(depth_reg))
        else $error("state advanced while result register full");
`endif

endmodule

// File: verif/paged_stack_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the paged stack allocator, with a built-in allocator model.
module paged_stack_allocator_tb;
    import psa_pkg::*;

    localparam int PAGES            = 16;
    localparam int MARKS            = 16;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 265;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    psa_req_t    req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    psa_rsp_t    rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // allocator model state
    logic [31:0] dflt_size;
    logic [31:0] cap_tab   [PAGES];
    logic [31:0] fill_tab  [PAGES];
    logic [3:0]  mark_pg   [MARKS];
    logic [31:0] mark_fill [MARKS];
    int unsigned page_cnt;
    int unsigned cur_pg;
    int unsigned mark_cnt;

    psa_req_t    cmd_queue[$];
    psa_rsp_t    grants_due[$];
    int unsigned issued   = 0;
    int unsigned answered = 0;
    int          fail_cnt = 0;
    int          gap_left = 0;
    int          gap_pct  = 0;
    int          stall_left = 0;
    int          stall_pct  = 0;
    int unsigned cycles   = 0;

    paged_stack_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic psa_rsp_t current_page_view(status_t st);
        psa_rsp_t r;
        r.status        = st;
        r.page_index    = cur_pg[3:0];
        r.offset        = fill_tab[cur_pg];
        r.new_page      = 1'b0;
        r.page_capacity = cap_tab[cur_pg];
        return r;
    endfunction

    function automatic psa_rsp_t page_grant(int unsigned pg, logic [31:0] off, logic fresh);
        psa_rsp_t r;
        r.status        = STATUS_OK;
        r.page_index    = pg[3:0];
        r.offset        = off;
        r.new_page      = fresh;
        r.page_capacity = cap_tab[pg];
        return r;
    endfunction

    // Apply one command to the model and return the result it must produce.
    function automatic psa_rsp_t allocator_step(psa_req_t c);
        logic [63:0] amask;
        logic [63:0] aligned;
        psa_rsp_t    r;
        case (c.cmd)
            CMD_ALLOC:
            begin
                amask   = (64'd1 << c.align_log2) - 64'd1;
                aligned = ({32'd0, fill_tab[cur_pg]} + amask) & ~amask;
                if (aligned + {32'd0, c.size} <= {32'd0, cap_tab[cur_pg]})
                begin
                    fill_tab[cur_pg] = aligned[31:0] + c.size;
                    r = page_grant(cur_pg, aligned[31:0], 1'b0);
                end
                else if (cur_pg + 1 < page_cnt)
                begin
                    // pooled page: refuse when it is too small, else restart at zero
                    if (c.size > cap_tab[cur_pg + 1])
                        r = current_page_view(STATUS_TOO_SMALL);
                    else
                    begin
                        cur_pg = cur_pg + 1;
                        fill_tab[cur_pg] = c.size;
                        r = page_grant(cur_pg, 32'd0, 1'b0);
                    end
                end
                else if (page_cnt >= PAGES)
                    r = current_page_view(STATUS_TABLE_FULL);
                else
                begin
                    cap_tab[page_cnt]  = (c.size > dflt_size) ? c.size : dflt_size;
                    fill_tab[page_cnt] = c.size;
                    cur_pg             = page_cnt;
                    page_cnt           = page_cnt + 1;
                    r = page_grant(cur_pg, 32'd0, 1'b1);
                end
            end
            CMD_PUSH:
            begin
                if (mark_cnt >= MARKS)
                    r = current_page_view(STATUS_MARKS_FULL);
                else
                begin
                    mark_pg[mark_cnt]   = cur_pg[3:0];
                    mark_fill[mark_cnt] = fill_tab[cur_pg];
                    mark_cnt            = mark_cnt + 1;
                    r = current_page_view(STATUS_OK);
                end
            end
            CMD_POP:
            begin
                if (mark_cnt == 0)
                    r = current_page_view(STATUS_NO_MARK);
                else
                begin
                    mark_cnt         = mark_cnt - 1;
                    cur_pg           = 32'(mark_pg[mark_cnt]);
                    fill_tab[cur_pg] = mark_fill[mark_cnt];
                    r = current_page_view(STATUS_OK);
                end
            end
            default:
            begin
                // reset command: back to page zero, keep the pool
                mark_cnt    = 0;
                cur_pg      = 0;
                fill_tab[0] = 32'd0;
                r = current_page_view(STATUS_OK);
            end
        endcase
        return r;
    endfunction

    function automatic void enqueue(cmd_t c, logic [31:0] size, logic [4:0] lg);
        psa_req_t r;
        r.cmd        = c;
        r.size       = size;
        r.align_log2 = lg;
        cmd_queue = {cmd_queue, r};
        issued++;
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(60000, 70000);
            4:       return $urandom_range(0, dflt_size);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    function automatic logic [4:0] rand_align();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 4));
    endfunction

    // Queue one random sequence and return how many commands it holds.
    function automatic int queue_random_sequence();
        int n;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            // mark frame: push, allocate a few, pop
            n = $urandom_range(1, 8);
            enqueue(CMD_PUSH, $urandom, rand_align());
            repeat (n) enqueue(CMD_ALLOC, rand_size(), rand_align());
            enqueue(CMD_POP, $urandom, rand_align());
            return n + 2;
        end
        else if (kind < 70)
        begin
            n = $urandom_range(2, 12);
            repeat (n) enqueue(CMD_ALLOC, rand_size(), rand_align());
            return n;
        end
        else if (kind < 78)
        begin
            n = $urandom_range(10, 20);
            repeat (n) enqueue(CMD_PUSH, $urandom, rand_align());
            return n;
        end
        else if (kind < 85)
        begin
            n = $urandom_range(1, 20);
            repeat (n) enqueue(CMD_POP, $urandom, rand_align());
            return n;
        end
        else if (kind < 95)
        begin
            n = $urandom_range(1, 6);
            enqueue(CMD_RESET, $urandom, rand_align());
            repeat (n) enqueue(CMD_ALLOC, rand_size(), rand_align());
            return n + 1;
        end
        n = $urandom_range(1, 4);
        repeat (n) enqueue(cmd_t'($urandom_range(0, 3)), $urandom, 5'($urandom_range(0, 31)));
        return n;
    endfunction

    function automatic void queue_directed();
        enqueue(CMD_ALLOC, 32'd0, 5'd0);
        enqueue(CMD_ALLOC, 32'd100, 5'd0);
        enqueue(CMD_ALLOC, 32'd8, 5'd4);
        // huge alignment overruns page zero and appends a page
        enqueue(CMD_ALLOC, 32'd1, 5'd31);
        enqueue(CMD_PUSH, 32'hFFFF_FFFF, 5'd31);
        // request above the default size sets the new page's capacity
        enqueue(CMD_ALLOC, 32'hFFFF_FFFF, 5'd0);
        enqueue(CMD_POP, 32'd0, 5'd0);
        enqueue(CMD_POP, 32'd0, 5'd0);
        enqueue(CMD_RESET, 32'd0, 5'd0);
        // next pooled page cannot hold this
        enqueue(CMD_ALLOC, 32'd70000, 5'd0);
        enqueue(CMD_ALLOC, 32'd65536, 5'd0);
        enqueue(CMD_ALLOC, 32'd1, 5'd0);
        enqueue(CMD_ALLOC, 32'd65535, 5'd3);
        enqueue(CMD_RESET, 32'hFFFF_FFFF, 5'd31);
    endfunction

    task automatic write_page_size(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dflt_size  = value;
        cap_tab[0] = value;
    endtask

    always @(posedge clk)
    begin : feed
        logic     next_valid;
        psa_req_t next_req;
        psa_rsp_t due;
        next_valid = req_valid;
        next_req   = req;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                due        = allocator_step(req);
                grants_due = {grants_due, due};
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() > 0)
                begin
                    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
                        gap_left = $urandom_range(1, 8) - 1;
                    else
                    begin
                        next_req   = cmd_queue.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            req_valid <= next_valid;
            req       <= next_req;
        end
    end

    always @(posedge clk)
    begin : collect
        psa_rsp_t want;
        logic     next_ready;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("result beat with nothing expected: status %0d page %0d",
                                 rsp.status, rsp.page_index);
                end
                else
                begin
                    want = grants_due.pop_front();
                    answered++;
                    if (rsp.status !== want.status || rsp.page_index !== want.page_index ||
                        rsp.offset !== want.offset || rsp.new_page !== want.new_page ||
                        rsp.page_capacity !== want.page_capacity)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display({"mismatch: expected status %0d page %0d offset %h ",
                                      "new %0d cap %h, got status %0d page %0d offset %h ",
                                      "new %0d cap %h"},
                                     want.status, want.page_index, want.offset,
                                     want.new_page, want.page_capacity,
                                     rsp.status, rsp.page_index, rsp.offset,
                                     rsp.new_page, rsp.page_capacity);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            rsp_ready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("paged_stack_allocator verification failed");
            $finish;
        end
    end

    initial
    begin : sequencer
        logic [31:0] page_sizes [PHASES];
        int          gaps       [PHASES];
        int          stalls     [PHASES];
        int          added;
        page_sizes = '{32'd65536, 32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd256, 32'd0};
        gaps       = '{20, 0, 35, 10, 25, 0};
        stalls     = '{20, 30, 0, 35, 10, 0};
        page_sizes[5] = $urandom_range(2, 100000);

        dflt_size = 32'd65536;
        for (int i = 0; i < PAGES; i++)
            fill_tab[i] = 32'd0;
        cap_tab[0] = dflt_size;
        page_cnt   = 1;
        cur_pg     = 0;
        mark_cnt   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // hold the sender until every result of the last phase is in
            while (answered != issued) @(posedge clk);
            repeat (4) @(posedge clk);
            write_page_size(page_sizes[ph]);
            gap_pct   = gaps[ph];
            stall_pct = stalls[ph];
            if (ph == 0)
                queue_directed();
            added = 0;
            while (added < RANDOM_PER_PHASE)
                added += queue_random_sequence();
        end

        while (answered != issued) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_cnt == 0 && grants_due.size() == 0)
            $display("paged_stack_allocator verification clean");
        else
            $display("paged_stack_allocator verification failed");
        $finish;
    end

endmodule
